// ===== design/sta_pkg.sv =====
// Shared constants, item tag type and exponent table function for the activation unit.
package sta_pkg;

	localparam int unsigned FRAC_BITS  = 62;
	localparam int unsigned EXP_BITS   = 17;
	localparam int unsigned A_BITS     = 62;
	localparam int unsigned SLOPE_BITS = 19;
	localparam int unsigned DIV_W      = 64;
	localparam int unsigned E_W        = 63;
	localparam int unsigned QV_W       = 17;

	localparam logic [E_W-1:0] Q_ONE = 63'h4000_0000_0000_0000;

	localparam logic FSEL_SIGMOID = 1'b0;
	localparam logic FSEL_TANH    = 1'b1;

	typedef struct packed {
		logic            neg;
		logic            fsel;
		logic [QV_W-1:0] qv;
	} sta_tag_t;

	// exp(-2^k/1024) in Q0.62: truncated series for the base, then repeated squaring
	function automatic logic [FRAC_BITS-1:0] exp_factor(input int unsigned k);
		logic [63:0]  t;
		logic [63:0]  p;
		logic [127:0] sq;
		t = 64'(Q_ONE) >> 10;
		p = 64'(Q_ONE) - t;
		t = (t >> 10) / 2;
		p = p + t;
		t = (t >> 10) / 3;
		p = p - t;
		t = (t >> 10) / 4;
		p = p + t;
		t = (t >> 10) / 5;
		p = p - t;
		for (int unsigned i = 0; i < k; i++) begin
			sq = 128'(p) * 128'(p);
			p  = sq[125:62];
		end
		return p[FRAC_BITS-1:0];
	endfunction

endpackage

// ===== design/sigmoid_tanh_activation_core.sv =====
// Stages from input accept to m_tvalid: input, exp, prep, value divide, slope divide, output.
// Throughput: one word per cycle if not stalled; exp multiplies, both dividers fully pipelined.
// A stalled output word freezes every stage; input is taken while the output register drains.
// The divide chain (62 + 19 restoring stages) sets most of the latency.
// Reset clears all valid bits and selects the sigmoid; data registers are not reset.
module sigmoid_tanh_activation_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] value, [31:16] slope
);

	localparam int unsigned SIG_SHIFT = sta_pkg::FRAC_BITS - 16;
	localparam int unsigned TNH_SHIFT = sta_pkg::FRAC_BITS - 17;
	localparam logic [sta_pkg::QV_W-1:0] QV_ONE = 17'h10000;
	localparam logic [16:0] VAL_MAX   = 17'd32767;
	localparam logic [19:0] SLOPE_MAX = 20'd65535;

	logic                          fsel_q;
	logic                          en;

	logic                          vld_s1;
	logic [sta_pkg::EXP_BITS-1:0]  arg_s1;
	sta_pkg::sta_tag_t             tag_s1;
	logic [15:0]                   mag;

	logic                          e_vld;
	logic [sta_pkg::E_W-1:0]       e_val;
	sta_pkg::sta_tag_t             e_tag;

	logic                          vld_s2;
	logic [sta_pkg::DIV_W-1:0]     num_s2;
	logic [sta_pkg::DIV_W-1:0]     den_s2;
	sta_pkg::sta_tag_t             tag_s2;

	logic                          a_vld;
	logic [sta_pkg::A_BITS-1:0]    a_quo;
	logic [sta_pkg::DIV_W-1:0]     a_rem;
	logic [sta_pkg::DIV_W-1:0]     a_den;
	sta_pkg::sta_tag_t             a_tag;

	logic                          inexact_s;
	logic                          inexact_t;
	logic [sta_pkg::QV_W-1:0]      qv;
	sta_pkg::sta_tag_t             b_tag_in;

	logic                          b_vld;
	logic [sta_pkg::SLOPE_BITS-1:0] b_quo;
	sta_pkg::sta_tag_t             b_tag;

	logic [16:0]                   v_rnd;
	logic [15:0]                   value;
	logic [sta_pkg::SLOPE_BITS-1:0] q_sl;
	logic [19:0]                   sl_rnd;
	logic [15:0]                   slope;

	logic                          out_vld_q;
	logic [31:0]                   out_data_q;

	// advance the whole pipeline unless the output word is held
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q <= sta_pkg::FSEL_SIGMOID;
		end else if (cfg_we) begin
			fsel_q <= cfg_wdata;
		end
	end

	assign mag = s_tdata[15] ? (~s_tdata) + 16'd1 : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= e_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1      <= (fsel_q == sta_pkg::FSEL_TANH) ? {mag, 1'b0} : {1'b0, mag};
			tag_s1.neg  <= s_tdata[15];
			tag_s1.fsel <= fsel_q;
			tag_s1.qv   <= '0;
			num_s2      <= 64'(e_val);
			den_s2      <= 64'(e_val) + 64'(sta_pkg::Q_ONE);
			tag_s2      <= e_tag;
		end
	end

	sta_exp_pipe u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_arg    (arg_s1),
		.in_tag    (tag_s1),
		.out_valid (e_vld),
		.out_e     (e_val),
		.out_tag   (e_tag)
	);

	// a = floor(2^62 * e / D)
	sta_div_pipe #(
		.QBITS (sta_pkg::A_BITS)
	) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_num    (num_s2),
		.in_den    (den_s2),
		.in_tag    (tag_s2),
		.out_valid (a_vld),
		.out_quo   (a_quo),
		.out_rem   (a_rem),
		.out_den   (a_den),
		.out_tag   (a_tag)
	);

	// value quotient from a: 1 - e/D and 1 - 2e/D use the ceiling of the scaled a
	assign inexact_s = (a_quo[SIG_SHIFT-1:0] != '0) || (a_rem != '0);
	assign inexact_t = (a_quo[TNH_SHIFT-1:0] != '0) || (a_rem != '0);

	always_comb begin
		if (a_tag.fsel == sta_pkg::FSEL_TANH) begin
			qv = QV_ONE - (17'(a_quo >> TNH_SHIFT) + 17'(inexact_t));
		end else if (a_tag.neg) begin
			qv = 17'(a_quo >> SIG_SHIFT);
		end else begin
			qv = QV_ONE - (17'(a_quo >> SIG_SHIFT) + 17'(inexact_s));
		end
	end

	assign b_tag_in.neg  = a_tag.neg;
	assign b_tag_in.fsel = a_tag.fsel;
	assign b_tag_in.qv   = qv;

	sta_div_pipe #(
		.QBITS (sta_pkg::SLOPE_BITS)
	) u_div_s (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (a_vld),
		.in_num    (64'(a_quo)),
		.in_den    (a_den),
		.in_tag    (b_tag_in),
		.out_valid (b_vld),
		.out_quo   (b_quo),
		.out_rem   (),
		.out_den   (),
		.out_tag   (b_tag)
	);

	// round to nearest, then negate or saturate
	always_comb begin
		v_rnd = (b_tag.qv + 17'd1) >> 1;
		if (b_tag.fsel == sta_pkg::FSEL_TANH && b_tag.neg) begin
			value = (~v_rnd[15:0]) + 16'd1;
		end else if (v_rnd > VAL_MAX) begin
			value = VAL_MAX[15:0];
		end else begin
			value = v_rnd[15:0];
		end
		q_sl   = (b_tag.fsel == sta_pkg::FSEL_TANH) ? b_quo : {2'b00, b_quo[18:2]};
		sl_rnd = (20'(q_sl) + 20'd1) >> 1;
		slope  = (sl_rnd > SLOPE_MAX) ? SLOPE_MAX[15:0] : sl_rnd[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= b_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {slope, value};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_exp_bound : assert property (@(posedge clk) disable iff (!arst_n)
		e_vld |-> (e_val <= sta_pkg::Q_ONE))
		else $error("exp result above one");

	a_ratio_bound : assert property (@(posedge clk) disable iff (!arst_n)
		a_vld |-> (a_quo <= 62'h2000_0000_0000_0000))
		else $error("e/D quotient above one half");

	a_sig_slope : assert property (@(posedge clk) disable iff (!arst_n)
		(b_vld && b_tag.fsel == sta_pkg::FSEL_SIGMOID) |-> (b_quo <= 19'h20000))
		else $error("sigmoid slope quotient above one quarter");

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_s1) |=> vld_s1)
		else $error("input stage lost a word during a stall");
`endif

endmodule

// ===== design/sta_exp_pipe.sv =====
// Pipelined exp(-a/1024): one constant multiply per exponent bit, two stages each.
module sta_exp_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [sta_pkg::EXP_BITS-1:0]   in_arg,
	input  sta_pkg::sta_tag_t              in_tag,
	output logic                           out_valid,
	output logic [sta_pkg::E_W-1:0]        out_e,
	output sta_pkg::sta_tag_t              out_tag
);

	localparam int unsigned N = sta_pkg::EXP_BITS;
	localparam int unsigned W = sta_pkg::E_W;

	logic              vld_a_s [N];
	logic              vld_b_s [N];
	logic [63:0]       ll_a_s  [N];
	logic [63:0]       lh_a_s  [N];
	logic [63:0]       hl_a_s  [N];
	logic [63:0]       hh_a_s  [N];
	logic [W-1:0]      r_a_s   [N];
	logic [W-1:0]      r_b_s   [N];
	logic [N-1:0]      arg_a_s [N];
	logic [N-1:0]      arg_b_s [N];
	sta_pkg::sta_tag_t tag_a_s [N];
	sta_pkg::sta_tag_t tag_b_s [N];

	for (genvar k = 0; k < N; k++) begin : g_iter
		localparam logic [sta_pkg::FRAC_BITS-1:0] EK = sta_pkg::exp_factor(k);

		logic              vld_in;
		logic [W-1:0]      r_in;
		logic [N-1:0]      arg_in;
		sta_pkg::sta_tag_t tag_in;
		logic [127:0]      full;

		if (k == 0) begin : g_head
			assign vld_in = in_valid;
			assign r_in   = sta_pkg::Q_ONE;
			assign arg_in = in_arg;
			assign tag_in = in_tag;
		end else begin : g_tail
			assign vld_in = vld_b_s[k-1];
			assign r_in   = r_b_s[k-1];
			assign arg_in = arg_b_s[k-1];
			assign tag_in = tag_b_s[k-1];
		end

		assign full = 128'(ll_a_s[k]) + (128'(lh_a_s[k]) << 32) +
			(128'(hl_a_s[k]) << 32) + (128'(hh_a_s[k]) << 64);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s[k] <= 1'b0;
				vld_b_s[k] <= 1'b0;
			end else if (en) begin
				vld_a_s[k] <= vld_in;
				vld_b_s[k] <= vld_a_s[k];
			end
		end

		// partial products first, then the sum and the Q0.62 truncation
		always_ff @(posedge clk) begin
			if (en) begin
				ll_a_s[k]  <= r_in[31:0] * EK[31:0];
				lh_a_s[k]  <= r_in[31:0] * EK[61:32];
				hl_a_s[k]  <= r_in[62:32] * EK[31:0];
				hh_a_s[k]  <= r_in[62:32] * EK[61:32];
				r_a_s[k]   <= r_in;
				arg_a_s[k] <= arg_in;
				tag_a_s[k] <= tag_in;
				r_b_s[k]   <= arg_a_s[k][k] ? full[124:62] : r_a_s[k];
				arg_b_s[k] <= arg_a_s[k];
				tag_b_s[k] <= tag_a_s[k];
			end
		end
	end

	assign out_valid = vld_b_s[N-1];
	assign out_e     = r_b_s[N-1];
	assign out_tag   = tag_b_s[N-1];

endmodule

// ===== design/sta_div_pipe.sv =====
// Pipelined restoring divider: floor(num * 2^QBITS / den), one quotient bit per stage.
module sta_div_pipe #(
	parameter int unsigned QBITS = sta_pkg::A_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [sta_pkg::DIV_W-1:0]     in_num,
	input  logic [sta_pkg::DIV_W-1:0]     in_den,
	input  sta_pkg::sta_tag_t             in_tag,
	output logic                          out_valid,
	output logic [QBITS-1:0]              out_quo,
	output logic [sta_pkg::DIV_W-1:0]     out_rem,
	output logic [sta_pkg::DIV_W-1:0]     out_den,
	output sta_pkg::sta_tag_t             out_tag
);

	localparam int unsigned W = sta_pkg::DIV_W;

	logic              vld_s [QBITS];
	logic [W-1:0]      rem_s [QBITS];
	logic [W-1:0]      den_s [QBITS];
	logic [QBITS-1:0]  quo_s [QBITS];
	sta_pkg::sta_tag_t tag_s [QBITS];

	for (genvar i = 0; i < QBITS; i++) begin : g_bit
		logic              vld_in;
		logic [W-1:0]      rem_in;
		logic [W-1:0]      den_in;
		logic [QBITS-1:0]  quo_in;
		sta_pkg::sta_tag_t tag_in;
		logic [W:0]        shl;
		logic [W:0]        diff;
		logic              ge;

		if (i == 0) begin : g_head
			assign vld_in = in_valid;
			assign rem_in = in_num;
			assign den_in = in_den;
			assign quo_in = '0;
			assign tag_in = in_tag;
		end else begin : g_tail
			assign vld_in = vld_s[i-1];
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign tag_in = tag_s[i-1];
		end

		assign shl  = {rem_in, 1'b0};
		assign diff = shl - {1'b0, den_in};
		assign ge   = shl >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[W-1:0] : shl[W-1:0];
				quo_s[i] <= {quo_in[QBITS-2:0], ge};
				den_s[i] <= den_in;
				tag_s[i] <= tag_in;
			end
		end
	end

	assign out_valid = vld_s[QBITS-1];
	assign out_quo   = quo_s[QBITS-1];
	assign out_rem   = rem_s[QBITS-1];
	assign out_den   = den_s[QBITS-1];
	assign out_tag   = tag_s[QBITS-1];

endmodule
